// ===== src/cldl_pkg.sv =====
`timescale 1ns / 1ps

package cldl_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int ROW_W        = 6;
    localparam int LINK_W       = 7;
    localparam int MAP_W        = 64;
    localparam int DEPTH_W      = 7;

    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [LINK_W-1:0] link_t;

    // bit 6 of a link marks "no neighbour"
    localparam link_t LINK_NONE = 7'h40;

    localparam logic [2:0] OP_RESTART = 3'd0;
    localparam logic [2:0] OP_UP      = 3'd1;
    localparam logic [2:0] OP_DOWN    = 3'd2;
    localparam logic [2:0] OP_DELETE  = 3'd3;
    localparam logic [2:0] OP_RESTORE = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_END     = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic [1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [1:0] CFG_START_ROW = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [5:0] steps;
    } req_t;

    typedef struct packed {
        logic [5:0]         cursor;
        logic [MAP_W-1:0]   present_map;
        logic [DEPTH_W-1:0] undo_depth;
        logic [1:0]         status;
    } res_t;

    typedef struct packed {
        logic  hit;
        link_t link;
    } lnk_rd_t;

    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctl_t;

    // link of a row that has not been rewritten since the last rebuild
    function automatic link_t dflt_next(row_t row, logic [DEPTH_W-1:0] n);
        logic [DEPTH_W-1:0] succ;
        succ = {1'b0, row} + 7'd1;
        return (succ < n) ? succ : LINK_NONE;
    endfunction

    function automatic link_t dflt_prev(row_t row, logic [DEPTH_W-1:0] n);
        logic [DEPTH_W-1:0] here;
        here = {1'b0, row};
        return (row != '0 && here < n) ? (here - 7'd1) : LINK_NONE;
    endfunction

    function automatic logic [MAP_W-1:0] full_mask(logic [DEPTH_W-1:0] n);
        logic [MAP_W-1:0] m;
        if (n[6])
        begin
            m = '1;
        end
        else
        begin
            m = (64'd1 << n[5:0]) - 64'd1;
        end
        return m;
    endfunction

endpackage

// ===== src/cldl_undo_cell.sv =====
`timescale 1ns / 1ps

module cldl_undo_cell (
    input  logic                 clk,
    input  cldl_pkg::shift_ctl_t ctl,
    input  cldl_pkg::row_t       from_above,
    input  cldl_pkg::row_t       from_below,
    output cldl_pkg::row_t       row
);

    cldl_pkg::row_t row_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            row_reg <= from_above;
        end
        else if (ctl.pop)
        begin
            row_reg <= from_below;
        end
    end

    assign row = row_reg;

endmodule

// ===== src/cldl_undo_chain.sv =====
`timescale 1ns / 1ps

// LIFO as a row of cells: push moves every entry one cell down, pop one up
module cldl_undo_chain #(
    parameter int DEPTH = cldl_pkg::MAX_ROWS_DEF
) (
    input  logic                 clk,
    input  cldl_pkg::shift_ctl_t ctl,
    input  cldl_pkg::row_t       push_row,
    output cldl_pkg::row_t       top_row
);

    cldl_pkg::row_t cell_q     [DEPTH];
    cldl_pkg::row_t cell_above [DEPTH];
    cldl_pkg::row_t cell_below [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_top
                assign cell_above[i] = push_row;
            end
            else
            begin : g_inner_a
                assign cell_above[i] = cell_q[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_bottom
                assign cell_below[i] = '0;
            end
            else
            begin : g_inner_b
                assign cell_below[i] = cell_q[i+1];
            end

            cldl_undo_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .from_above (cell_above[i]),
                .from_below (cell_below[i]),
                .row        (cell_q[i])
            );
        end
    endgenerate

    assign top_row = cell_q[0];

endmodule

// ===== src/cldl_link_ram.sv =====
`timescale 1ns / 1ps

// One link table. Valid bits mark entries rewritten since the last rebuild;
// the owner substitutes the rebuilt chain value on a miss.
module cldl_link_ram #(
    parameter int DEPTH = cldl_pkg::MAX_ROWS_DEF,
    parameter int AW    = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  cldl_pkg::link_t   wr_data,
    input  logic [AW-1:0]     rd_addr,
    output cldl_pkg::lnk_rd_t rd
);

    cldl_pkg::link_t link_mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    cldl_pkg::link_t  rd_link_reg;
    logic             rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        rd_link_reg <= link_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_hit_reg <= vld_reg[rd_addr];
        end
    end

    assign rd = '{hit: rd_hit_reg, link: rd_link_reg};

endmodule

// ===== src/cursor_list_with_undo_delete.sv =====
`timescale 1ns / 1ps

// Restart, delete, restore and unused codes pass through the exec state once, then strobe done;
// up/down stay in exec for each link walked (one link per cycle through the link RAM), then strobe done.
// Handshake: busy drops the cycle after done; no new request is taken while busy is high.
// Results appear on done for one cycle only; the receiver cannot stall them.
// Reset: full list of MAX_ROWS rows, cursor on row 0, undo stack empty, no clearing pass needed.
module cursor_list_with_undo_delete #(
    parameter int MAX_ROWS = cldl_pkg::MAX_ROWS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cldl_pkg::req_t   request,
    output logic             done,
    output cldl_pkg::res_t   result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [6:0]       cfg_data
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [6:0] MAX_N = 7'(MAX_ROWS);

    cldl_pkg::state_t state_reg, state_next;

    logic [2:0]      op_reg, op_next;
    logic [5:0]      steps_reg, steps_next;
    cldl_pkg::row_t  cursor_reg, cursor_next;
    logic [63:0]     present_reg, present_next;
    logic [6:0]      depth_reg, depth_next;
    logic [1:0]      status_reg, status_next;
    logic [6:0]      n_reg, n_next;
    logic [6:0]      row_count_reg;
    cldl_pkg::row_t  start_row_reg;
    cldl_pkg::row_t  rd_addr, rd_addr_reg;

    cldl_pkg::lnk_rd_t nxt_rd, prv_rd;
    cldl_pkg::link_t   cur_next_link, cur_prev_link, move_link;

    logic            lnk_clear;
    logic            next_wr_en, prev_wr_en;
    cldl_pkg::row_t  next_wr_addr, prev_wr_addr;
    cldl_pkg::link_t next_wr_data, prev_wr_data;

    cldl_pkg::shift_ctl_t stk_ctl;
    cldl_pkg::row_t       stk_top;

    logic [6:0]     n_clamp, n_less1;
    cldl_pkg::row_t start_clamp;
    logic           is_move;

    assign n_clamp = (row_count_reg < 7'd2) ? 7'd2 :
                     (row_count_reg > MAX_N) ? MAX_N : row_count_reg;
    assign n_less1 = n_clamp - 7'd1;
    assign start_clamp = ({1'b0, start_row_reg} >= n_clamp) ? n_less1[5:0] : start_row_reg;

    assign cur_next_link = nxt_rd.hit ? nxt_rd.link : cldl_pkg::dflt_next(rd_addr_reg, n_reg);
    assign cur_prev_link = prv_rd.hit ? prv_rd.link : cldl_pkg::dflt_prev(rd_addr_reg, n_reg);
    assign is_move   = op_reg inside {cldl_pkg::OP_UP, cldl_pkg::OP_DOWN};
    assign move_link = (op_reg == cldl_pkg::OP_UP) ? cur_prev_link : cur_next_link;

    cldl_link_ram #(.DEPTH(MAX_ROWS), .AW(AW)) u_next_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (lnk_clear),
        .wr_en   (next_wr_en),
        .wr_addr (next_wr_addr[AW-1:0]),
        .wr_data (next_wr_data),
        .rd_addr (rd_addr[AW-1:0]),
        .rd      (nxt_rd)
    );

    cldl_link_ram #(.DEPTH(MAX_ROWS), .AW(AW)) u_prev_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (lnk_clear),
        .wr_en   (prev_wr_en),
        .wr_addr (prev_wr_addr[AW-1:0]),
        .wr_data (prev_wr_data),
        .rd_addr (rd_addr[AW-1:0]),
        .rd      (prv_rd)
    );

    cldl_undo_chain #(.DEPTH(MAX_ROWS)) u_undo (
        .clk      (clk),
        .ctl      (stk_ctl),
        .push_row (cursor_reg),
        .top_row  (stk_top)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cldl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = cldl_pkg::S_EXEC;
                end
            end
            cldl_pkg::S_EXEC:
            begin
                if (!(is_move && steps_reg != '0 && !move_link[6]))
                begin
                    state_next = cldl_pkg::S_DONE;
                end
            end
            cldl_pkg::S_DONE:
            begin
                state_next = cldl_pkg::S_IDLE;
            end
            default:
            begin
                state_next = cldl_pkg::S_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        busy = (state_reg != cldl_pkg::S_IDLE);
        done = (state_reg == cldl_pkg::S_DONE);
    end

    // datapath and link table control
    always_comb
    begin
        op_next      = op_reg;
        steps_next   = steps_reg;
        cursor_next  = cursor_reg;
        present_next = present_reg;
        depth_next   = depth_reg;
        status_next  = status_reg;
        n_next       = n_reg;
        rd_addr      = cursor_reg;
        lnk_clear    = 1'b0;
        next_wr_en   = 1'b0;
        prev_wr_en   = 1'b0;
        next_wr_addr = cursor_reg;
        prev_wr_addr = cursor_reg;
        next_wr_data = cldl_pkg::LINK_NONE;
        prev_wr_data = cldl_pkg::LINK_NONE;
        stk_ctl      = '0;

        case (state_reg)
            cldl_pkg::S_IDLE:
            begin
                // restore needs the links of the row it brings back
                rd_addr = (request.operation == cldl_pkg::OP_RESTORE) ? stk_top : cursor_reg;
                if (start)
                begin
                    op_next     = request.operation;
                    steps_next  = request.steps;
                    status_next = cldl_pkg::ST_OK;
                end
            end
            cldl_pkg::S_EXEC:
            begin
                if (op_reg == cldl_pkg::OP_RESTART)
                begin
                    n_next       = n_clamp;
                    present_next = cldl_pkg::full_mask(n_clamp);
                    depth_next   = '0;
                    cursor_next  = start_clamp;
                    lnk_clear    = 1'b1;
                end
                else if (is_move)
                begin
                    if (steps_reg != '0)
                    begin
                        if (move_link[6])
                        begin
                            status_next = cldl_pkg::ST_END;
                        end
                        else
                        begin
                            cursor_next = move_link[5:0];
                            steps_next  = steps_reg - 6'd1;
                            rd_addr     = move_link[5:0];
                        end
                    end
                end
                else if (op_reg == cldl_pkg::OP_DELETE)
                begin
                    if (cur_prev_link[6] && cur_next_link[6])
                    begin
                        status_next = cldl_pkg::ST_REFUSED;
                    end
                    else
                    begin
                        stk_ctl.push = 1'b1;
                        depth_next   = depth_reg + 7'd1;
                        present_next = present_reg & ~(64'd1 << cursor_reg);
                        // next[p] <= nx covers both the middle and the last-row case
                        next_wr_en   = !cur_prev_link[6];
                        next_wr_addr = cur_prev_link[5:0];
                        next_wr_data = cur_next_link;
                        prev_wr_en   = !cur_next_link[6];
                        prev_wr_addr = cur_next_link[5:0];
                        prev_wr_data = cur_prev_link;
                        cursor_next  = cur_next_link[6] ? cur_prev_link[5:0]
                                                        : cur_next_link[5:0];
                    end
                end
                else if (op_reg == cldl_pkg::OP_RESTORE)
                begin
                    if (depth_reg == '0)
                    begin
                        status_next = cldl_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        stk_ctl.pop  = 1'b1;
                        depth_next   = depth_reg - 7'd1;
                        present_next = present_reg | (64'd1 << stk_top);
                        next_wr_en   = !cur_prev_link[6];
                        next_wr_addr = cur_prev_link[5:0];
                        next_wr_data = {1'b0, stk_top};
                        prev_wr_en   = !cur_next_link[6];
                        prev_wr_addr = cur_next_link[5:0];
                        prev_wr_data = {1'b0, stk_top};
                    end
                end
            end
            cldl_pkg::S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cldl_pkg::S_IDLE;
            op_reg      <= cldl_pkg::OP_RESTART;
            steps_reg   <= '0;
            cursor_reg  <= '0;
            present_reg <= cldl_pkg::full_mask(MAX_N);
            depth_reg   <= '0;
            status_reg  <= cldl_pkg::ST_OK;
            n_reg       <= MAX_N;
            rd_addr_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            steps_reg   <= steps_next;
            cursor_reg  <= cursor_next;
            present_reg <= present_next;
            depth_reg   <= depth_next;
            status_reg  <= status_next;
            n_reg       <= n_next;
            rd_addr_reg <= rd_addr;
        end
    end

    assign cfg_ready = 1'b1;

    // registers only take effect at the next restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= 7'd64;
            start_row_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cldl_pkg::CFG_ROW_COUNT: row_count_reg <= cfg_data;
                cldl_pkg::CFG_START_ROW: start_row_reg <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    assign result = '{cursor:      cursor_reg,
                      present_map: present_reg,
                      undo_depth:  depth_reg,
                      status:      status_reg};

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg < MAX_N)
        else $error("undo depth reached the row limit");

    a_cursor_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cldl_pkg::S_IDLE) |-> present_reg[cursor_reg])
        else $error("cursor sits on a deleted row");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        present_reg != '0)
        else $error("list lost its last row");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_refuse_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == cldl_pkg::ST_REFUSED) |->
            (depth_reg == $past(depth_reg) && present_reg == $past(present_reg)))
        else $error("refused delete changed the list");

endmodule
